/* sv/drs_pkg.sv */
package drs_pkg;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_SERVED   = 2'd2;
  localparam logic [1:0] ST_NONE     = 2'd3;

  localparam logic [1:0] MODE_FCFS  = 2'd0;
  localparam logic [1:0] MODE_SSTF  = 2'd1;
  localparam logic [1:0] MODE_SCAN  = 2'd2;
  localparam logic [1:0] MODE_CLOOK = 2'd3;

  localparam logic CFG_MODE = 1'b0;
  localparam logic CFG_TPSU = 1'b1;

  localparam int unsigned TW = 40;
  localparam logic [TW-1:0] TMAX = {TW{1'b1}};

  // One slot's contents as seen by the scan unit
  typedef struct packed {
    logic        valid;
    logic [39:0] arrival;
    logic [15:0] cyl;
    logic [31:0] order;
  } entry_t;

  // Scan pass context from the sequencer
  typedef struct packed {
    logic [2:0]  pass;
    logic [39:0] now;
    logic [15:0] head;
    logic [31:0] ocnt;
  } scan_ctx_t;

  localparam logic [2:0] P_EARLY = 3'd0;
  localparam logic [2:0] P_FCFS  = 3'd1;
  localparam logic [2:0] P_SSTF  = 3'd2;
  localparam logic [2:0] P_UP    = 3'd3;
  localparam logic [2:0] P_DOWN  = 3'd4;
  localparam logic [2:0] P_LOW   = 3'd5;
  localparam logic [2:0] P_FREE  = 3'd6;

endpackage

/* sv/disk_request_scheduler.sv */
// Disk request scheduler: pending request table with FCFS/SSTF/SCAN/CLOOK dispatch.
// Input channel (in_valid_i/in_stall_o): func_i 0 inserts a request into the
// lowest free slot, func_i 1 dispatches the next request per sched_mode.
// Output channel (out_valid_o/out_stall_i): one result item per input item.
// Config channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i): index 0
// sched_mode, 1 ticks_per_size_unit; others ignored. Write only while idle.
// Timing: a single compare unit scans the table one slot per cycle. An insert
// takes one free-slot pass. Dispatch: earliest-arrival pass, one selection
// pass, then read, multiply and finish steps; a SCAN reversal or a CLOOK wrap
// adds a pass. Empty table: the result follows the earliest-arrival pass.
// One item is in work at a time; in_stall_o is high from acceptance until the
// result register is free again, so the next item is taken only after the
// result has been accepted by the receiver.
// The result sits in an output register; while out_stall_i is high it holds
// and no new item is accepted.
// Reset: table empty, clock and head zero, sweep upward, mode FCFS, ticks 1.
// The table payload memories need no clearing; only valid bits are reset.
module disk_request_scheduler #(
  parameter int unsigned TABLE_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [39:0] arrival_time_i,
  input  logic [15:0] target_cylinder_i,
  input  logic [15:0] request_size_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [5:0]  slot_o,
  output logic [39:0] wait_ticks_o,
  output logic [39:0] finish_ticks_o,
  output logic [15:0] seek_distance_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [AW:0] LAST = (AW+1)'(TABLE_DEPTH - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;
  localparam logic [2:0] S_RD   = 3'd5;

  // Table storage
  logic [TABLE_DEPTH-1:0] vld_q;
  logic [39:0] arr_mem [TABLE_DEPTH];
  logic [15:0] cyl_mem [TABLE_DEPTH];
  logic [15:0] siz_mem [TABLE_DEPTH];
  logic [31:0] ord_mem [TABLE_DEPTH];

  logic [2:0]  state_q;
  logic [39:0] in_arr_q;
  logic [15:0] in_cyl_q, in_siz_q;
  logic [AW-1:0] idx_q;   // address issued this cycle
  logic        rv_q;      // read data valid this cycle
  logic [AW-1:0] ridx_q;
  logic        last_q;
  logic [39:0] rd_arr_q;
  logic [15:0] rd_cyl_q;
  logic [31:0] rd_ord_q;
  drs_pkg::entry_t ent;
  logic        have_q;
  logic [39:0] key_q;
  logic [AW-1:0] best_q;
  logic [15:0] best_siz_q;
  drs_pkg::scan_ctx_t ctx_q;
  logic [31:0] ocnt_q;
  logic        up_q;
  logic [1:0]  mode_q;
  logic [15:0] tpsu_q;
  logic [31:0] prod_q;
  logic [39:0] best_arr_q;
  logic [15:0] best_cyl_q;
  logic        scan_second_q;

  logic        take;
  logic [39:0] ckey;
  logic        scan_done;
  logic        found;

  assign ent = {vld_q[ridx_q], rd_arr_q, rd_cyl_q, rd_ord_q};

  drs_cmp u_cmp (
    .ctx_i (ctx_q), .ent_i (ent), .have_i (have_q), .key_i (key_q),
    .take_o(take),  .key_o (ckey)
  );

  logic [1:0]  o_st_q;
  logic [5:0]  o_slot_q;
  logic [39:0] o_wait_q, o_fin_q;
  logic [15:0] o_seek_q;
  logic        o_v_q;

  assign in_stall_o  = (state_q != S_IDLE) || o_v_q;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = o_v_q;
  assign status_o = o_st_q;
  assign slot_o = o_slot_q;
  assign wait_ticks_o = o_wait_q;
  assign finish_ticks_o = o_fin_q;
  assign seek_distance_o = o_seek_q;

  logic accept;
  assign accept = in_valid_i && !in_stall_o;
  assign scan_done = rv_q && last_q;
  assign found = have_q || take;

  logic [39:0] fin_sum;
  logic [40:0] fin_raw;
  assign fin_raw = {1'b0, ctx_q.now} + {9'd0, prod_q};
  assign fin_sum = fin_raw[40] ? drs_pkg::TMAX : fin_raw[39:0];

  // Memory write and registered read
  logic        wr_en;
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      arr_mem[best_q] <= in_arr_q;
      cyl_mem[best_q] <= in_cyl_q;
      siz_mem[best_q] <= in_siz_q;
      ord_mem[best_q] <= ocnt_q;
    end
    rd_arr_q   <= arr_mem[idx_q];
    rd_cyl_q   <= cyl_mem[idx_q];
    rd_ord_q   <= ord_mem[idx_q];
    best_siz_q <= siz_mem[best_q];
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; vld_q <= '0; ocnt_q <= '0; up_q <= 1'b1;
      mode_q <= drs_pkg::MODE_FCFS; tpsu_q <= 16'd1; o_v_q <= 1'b0;
      ctx_q <= '0; rv_q <= 1'b0; wr_en <= 1'b0; scan_second_q <= 1'b0;
      have_q <= 1'b0; in_arr_q <= '0; in_cyl_q <= '0; in_siz_q <= '0;
      idx_q <= '0; ridx_q <= '0; last_q <= 1'b0; key_q <= '0; best_q <= '0;
      prod_q <= '0; best_arr_q <= '0; best_cyl_q <= '0;
      o_st_q <= '0; o_slot_q <= '0; o_wait_q <= '0; o_fin_q <= '0; o_seek_q <= '0;
    end else begin
      wr_en <= 1'b0;
      if (cfg_valid_i) begin
        if (cfg_index_i == drs_pkg::CFG_MODE) mode_q <= cfg_data_i[1:0];
        else tpsu_q <= cfg_data_i;
      end
      if (o_v_q && !out_stall_i) o_v_q <= 1'b0;
      // scan pipeline
      if (state_q == S_SCAN) begin
        rv_q <= 1'b1; ridx_q <= idx_q; last_q <= ({1'b0, idx_q} == LAST);
        if ({1'b0, idx_q} != LAST) idx_q <= idx_q + AW'(1);
        if (rv_q && take) begin
          have_q <= 1'b1; key_q <= ckey; best_q <= ridx_q;
          best_arr_q <= ent.arrival; best_cyl_q <= ent.cyl;
        end
      end
      case (state_q)
        S_IDLE: if (accept) begin
          in_arr_q <= arrival_time_i;
          in_cyl_q <= target_cylinder_i; in_siz_q <= request_size_i;
          ctx_q.pass <= func_i ? drs_pkg::P_EARLY : drs_pkg::P_FREE;
          ctx_q.ocnt <= ocnt_q;
          idx_q <= '0; rv_q <= 1'b0; have_q <= 1'b0; scan_second_q <= 1'b0;
          state_q <= S_SCAN;
        end
        S_SCAN: if (scan_done) begin
          rv_q <= 1'b0; idx_q <= '0; have_q <= 1'b0;
          state_q <= S_SCAN;
          case (ctx_q.pass)
            drs_pkg::P_FREE: begin
              o_v_q <= 1'b1; state_q <= S_IDLE; o_wait_q <= '0;
              o_fin_q <= '0; o_seek_q <= '0;
              if (found) begin
                vld_q[take && !have_q ? ridx_q : best_q] <= 1'b1;
                best_q <= (take && !have_q) ? ridx_q : best_q;
                wr_en <= 1'b1; ocnt_q <= ocnt_q + 32'd1;
                o_st_q <= drs_pkg::ST_INSERTED;
                o_slot_q <= 6'((take && !have_q) ? ridx_q : best_q);
              end else begin
                o_st_q <= drs_pkg::ST_FULL; o_slot_q <= '0;
              end
            end
            drs_pkg::P_EARLY: begin
              if (!found) begin
                o_v_q <= 1'b1; state_q <= S_IDLE; o_st_q <= drs_pkg::ST_NONE;
                o_slot_q <= '0; o_wait_q <= '0; o_fin_q <= '0; o_seek_q <= '0;
              end else begin
                if ((take ? ckey : key_q) > ctx_q.now) ctx_q.now <= take ? ckey : key_q;
                case (mode_q)
                  drs_pkg::MODE_FCFS: ctx_q.pass <= drs_pkg::P_FCFS;
                  drs_pkg::MODE_SSTF: ctx_q.pass <= drs_pkg::P_SSTF;
                  drs_pkg::MODE_SCAN: ctx_q.pass <= up_q ? drs_pkg::P_UP : drs_pkg::P_DOWN;
                  default:            ctx_q.pass <= drs_pkg::P_UP;
                endcase
              end
            end
            default: begin
              if (found) begin
                if (take) best_q <= ridx_q;
                state_q <= S_RD;
              end else if (!scan_second_q && mode_q == drs_pkg::MODE_SCAN) begin
                scan_second_q <= 1'b1; up_q <= !up_q;
                ctx_q.pass <= up_q ? drs_pkg::P_DOWN : drs_pkg::P_UP;
              end else begin
                scan_second_q <= 1'b1; ctx_q.pass <= drs_pkg::P_LOW;
              end
            end
          endcase
        end
        S_RD: state_q <= S_MUL;
        S_MUL: begin
          prod_q <= 32'(best_siz_q) * 32'(tpsu_q);
          state_q <= S_FIN;
        end
        S_FIN: begin
          o_v_q <= 1'b1; o_st_q <= drs_pkg::ST_SERVED;
          o_slot_q <= 6'(best_q);
          o_wait_q <= ctx_q.now - best_arr_q;
          o_fin_q <= fin_sum;
          o_seek_q <= (best_cyl_q >= ctx_q.head) ? best_cyl_q - ctx_q.head
                                                 : ctx_q.head - best_cyl_q;
          ctx_q.head <= best_cyl_q; ctx_q.now <= fin_sum;
          vld_q[best_q] <= 1'b0;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> in_stall_o) else $error("accepted while busy");
  a_out_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> in_stall_o) else $error("ready during work");
  a_served_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) |-> vld_q[best_q]) else $error("serving empty slot");
`endif
endmodule

/* sv/drs_cmp.sv */
// Shared compare unit: folds one table entry per cycle into the running best
module drs_cmp (
  input  drs_pkg::scan_ctx_t ctx_i,
  input  drs_pkg::entry_t    ent_i,
  input  logic               have_i,
  input  logic [39:0]        key_i,
  output logic               take_o,
  output logic [39:0]        key_o
);
  logic        elig;
  logic [15:0] cdist;
  logic        cand;
  logic [39:0] k;
  logic        better;

  always_comb begin
    elig = ent_i.valid && (ent_i.arrival <= ctx_i.now);
    cdist = (ent_i.cyl >= ctx_i.head) ? ent_i.cyl - ctx_i.head : ctx_i.head - ent_i.cyl;
    cand = 1'b0;
    k = '0;
    better = 1'b0;
    case (ctx_i.pass)
      drs_pkg::P_EARLY: begin
        cand = ent_i.valid; k = ent_i.arrival; better = k < key_i;
      end
      drs_pkg::P_FCFS: begin
        cand = elig; k = {8'd0, ctx_i.ocnt - ent_i.order}; better = k > key_i;
      end
      drs_pkg::P_SSTF: begin
        cand = elig; k = {24'd0, cdist}; better = k < key_i;
      end
      drs_pkg::P_UP: begin
        cand = elig && (ent_i.cyl >= ctx_i.head); k = {24'd0, cdist}; better = k < key_i;
      end
      drs_pkg::P_DOWN: begin
        cand = elig && (ent_i.cyl <= ctx_i.head); k = {24'd0, cdist}; better = k < key_i;
      end
      drs_pkg::P_LOW: begin
        cand = elig; k = {24'd0, ent_i.cyl}; better = k < key_i;
      end
      drs_pkg::P_FREE: begin
        cand = !ent_i.valid; k = '0; better = 1'b0;
      end
      default: begin
        cand = 1'b0;
      end
    endcase
    take_o = cand && (!have_i || better);
    key_o = k;
  end
endmodule

/* sim/disk_request_scheduler_tb.sv */
`timescale 1ns / 100ps

module disk_request_scheduler_tb;

  localparam int DEPTH = 64;
  localparam logic [39:0] MASK40 = 40'hFF_FFFF_FFFF;
  localparam longint CYCLE_LIMIT = 3_000_000;

  typedef struct packed {
    logic [1:0]  status;
    logic [5:0]  slot;
    logic [39:0] wait_t;
    logic [39:0] finish;
    logic [15:0] seek;
  } sched_result_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, func_i;
  logic [39:0] arrival_time_i;
  logic [15:0] target_cylinder_i, request_size_i;
  logic        in_stall_o;
  logic        out_valid_o, out_stall_i;
  logic [1:0]  status_o;
  logic [5:0]  slot_o;
  logic [39:0] wait_ticks_o, finish_ticks_o;
  logic [15:0] seek_distance_o;
  logic        cfg_valid_i, cfg_ready_o;
  logic [0:0]  cfg_index_i;
  logic [15:0] cfg_data_i;

  disk_request_scheduler i_dut (.*);

  // Shadow of the block state
  bit          tbl_valid [DEPTH];
  logic [39:0] tbl_arr [DEPTH];
  logic [15:0] tbl_cyl [DEPTH];
  logic [15:0] tbl_size [DEPTH];
  logic [31:0] tbl_order [DEPTH];
  logic [31:0] order_cnt;
  logic [39:0] now_ticks;
  logic [15:0] head_cyl;
  bit          going_up;
  logic [1:0]  cur_mode;
  logic [15:0] cur_tpsu;

  sched_result_t expected_q[$];
  int  errors = 0;
  int  results_seen = 0;
  int  served_cnt = 0, full_cnt = 0, none_cnt = 0;
  int  send_idle_pct = 0, recv_stall_pct = 0;
  bit  hold_off = 0;
  longint cycles = 0;

  initial begin
    clk_i = 0;
    forever #10 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("disk_request_scheduler_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [15:0] dist16(logic [15:0] a, logic [15:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic bit ready_now(int i);
    return tbl_valid[i] && tbl_arr[i] <= now_ticks;
  endfunction

  function automatic int nearest_on_side(bit up);
    int best;
    logic [15:0] bd, d;
    best = -1;
    bd = 0;
    for (int i = 0; i < DEPTH; i++) begin
      if (!ready_now(i)) continue;
      if (up ? (tbl_cyl[i] < head_cyl) : (tbl_cyl[i] > head_cyl)) continue;
      d = dist16(tbl_cyl[i], head_cyl);
      if (best < 0 || d < bd) begin
        best = i;
        bd = d;
      end
    end
    return best;
  endfunction

  function automatic int choose_request();
    int best;
    logic [31:0] key, age;
    best = -1;
    key = 0;
    case (cur_mode)
      drs_pkg::MODE_FCFS: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!ready_now(i)) continue;
          age = order_cnt - tbl_order[i];
          if (best < 0 || age > key) begin
            best = i;
            key = age;
          end
        end
      end
      drs_pkg::MODE_SSTF: begin
        for (int i = 0; i < DEPTH; i++) begin
          if (!ready_now(i)) continue;
          age = 32'(dist16(tbl_cyl[i], head_cyl));
          if (best < 0 || age < key) begin
            best = i;
            key = age;
          end
        end
      end
      drs_pkg::MODE_SCAN: begin
        best = nearest_on_side(going_up);
        if (best < 0) begin
          going_up = !going_up;
          best = nearest_on_side(going_up);
        end
      end
      default: begin
        best = nearest_on_side(1'b1);
        if (best < 0) begin
          for (int i = 0; i < DEPTH; i++) begin
            if (!ready_now(i)) continue;
            if (best < 0 || 32'(tbl_cyl[i]) < key) begin
              best = i;
              key = 32'(tbl_cyl[i]);
            end
          end
        end
      end
    endcase
    return best;
  endfunction

  // Predict the result of one request item and update the shadow state
  function automatic sched_result_t schedule_item(logic f, logic [39:0] arr,
                                                  logic [15:0] cyl, logic [15:0] sz);
    sched_result_t r;
    bit any;
    logic [39:0] earliest;
    logic [55:0] fin;
    int s;
    r = '0;
    if (f == 1'b0) begin
      r.status = drs_pkg::ST_FULL;
      for (int i = 0; i < DEPTH; i++) begin
        if (!tbl_valid[i]) begin
          tbl_valid[i] = 1;
          tbl_arr[i] = arr;
          tbl_cyl[i] = cyl;
          tbl_size[i] = sz;
          tbl_order[i] = order_cnt;
          order_cnt++;
          r.status = drs_pkg::ST_INSERTED;
          r.slot = 6'(i);
          return r;
        end
      end
      return r;
    end
    any = 0;
    earliest = 0;
    for (int i = 0; i < DEPTH; i++)
      if (tbl_valid[i] && (!any || tbl_arr[i] < earliest)) begin
        earliest = tbl_arr[i];
        any = 1;
      end
    r.status = drs_pkg::ST_NONE;
    if (!any) return r;
    if (earliest > now_ticks) now_ticks = earliest;
    s = choose_request();
    if (s < 0) return r;
    fin = 56'(now_ticks) + 56'(tbl_size[s]) * 56'(cur_tpsu);
    if (fin > 56'(MASK40)) fin = 56'(MASK40);
    r.status = drs_pkg::ST_SERVED;
    r.slot = 6'(s);
    r.wait_t = now_ticks - tbl_arr[s];
    r.finish = fin[39:0];
    r.seek = dist16(tbl_cyl[s], head_cyl);
    head_cyl = tbl_cyl[s];
    now_ticks = fin[39:0];
    tbl_valid[s] = 0;
    return r;
  endfunction

  // Receiver stall
  always @(posedge clk_i) begin
    if (!rst_ni) out_stall_i <= 1'b0;
    else out_stall_i <= hold_off || ($urandom_range(99) < recv_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    sched_result_t exp_r, act;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      act = '{status_o, slot_o, wait_ticks_o, finish_ticks_o, seek_distance_o};
      results_seen++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, act);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (act.status != exp_r.status) begin
          $display("%0t: status exp %0d got %0d", $time, exp_r.status, act.status);
          errors++;
        end
        if (act.slot != exp_r.slot) begin
          $display("%0t: slot exp %0d got %0d", $time, exp_r.slot, act.slot);
          errors++;
        end
        if (act.wait_t != exp_r.wait_t) begin
          $display("%0t: wait exp %0d got %0d", $time, exp_r.wait_t, act.wait_t);
          errors++;
        end
        if (act.finish != exp_r.finish) begin
          $display("%0t: finish exp %0d got %0d", $time, exp_r.finish, act.finish);
          errors++;
        end
        if (act.seek != exp_r.seek) begin
          $display("%0t: seek exp %0d got %0d", $time, exp_r.seek, act.seek);
          errors++;
        end
        case (exp_r.status)
          drs_pkg::ST_SERVED: served_cnt++;
          drs_pkg::ST_FULL:   full_cnt++;
          drs_pkg::ST_NONE:   none_cnt++;
          default: ;
        endcase
      end
    end
  end

  // Send one request item, with optional idle gaps before it; valid stays
  // high after acceptance until the next item or an idle cycle replaces it
  task automatic send_request(logic f, logic [39:0] arr, logic [15:0] cyl,
                              logic [15:0] sz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= f;
    arrival_time_i <= arr;
    target_cylinder_i <= cyl;
    request_size_i <= sz;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(schedule_item(f, arr, cyl, sz));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (4 * DEPTH + 20) @(posedge clk_i);
  endtask

  // Register write; only called while the block is idle
  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (idx == drs_pkg::CFG_MODE) cur_mode = val[1:0];
    else cur_tpsu = val;
    @(posedge clk_i);
  endtask

  task automatic set_idling(int snd, int rcv);
    send_idle_pct = snd;
    recv_stall_pct = rcv;
  endtask

  // Dispatch until the table is empty
  task automatic empty_table();
    bit any;
    forever begin
      any = 0;
      for (int i = 0; i < DEPTH; i++) any |= tbl_valid[i];
      if (!any) break;
      send_request(1'b1, 40'($urandom), 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    write_reg(drs_pkg::CFG_MODE, drs_pkg::MODE_FCFS);
    write_reg(drs_pkg::CFG_TPSU, 16'd1);
    send_request(1'b1, '0, '0, '0);                         // empty table
    send_request(1'b0, MASK40, 16'hFFFF, 16'hFFFF);          // far future arrival
    send_request(1'b0, 40'd0, 16'd0, 16'd0);
    send_request(1'b0, 40'd5, 16'd100, 16'd3);
    send_request(1'b1, '0, '0, '0);
    send_request(1'b1, '0, '0, '0);
    send_request(1'b1, '0, '0, '0);
    send_request(1'b1, '0, '0, '0);                         // empty again after the clock jump and saturation
    send_request(1'b1, '0, '0, '0);
    drain();
    write_reg(drs_pkg::CFG_TPSU, 16'hFFFF);
    write_reg(drs_pkg::CFG_MODE, drs_pkg::MODE_SSTF);
    send_request(1'b0, 40'd0, 16'd50, 16'hFFFF);
    send_request(1'b0, 40'd0, 16'd50, 16'd1);               // tie, lowest slot
    send_request(1'b1, '0, '0, '0);
    send_request(1'b1, '0, '0, '0);
    drain();
  endtask

  // Fill the table completely, overflow, then drain it in the given mode
  task automatic test_table_full(logic [1:0] m);
    write_reg(drs_pkg::CFG_MODE, m);
    write_reg(drs_pkg::CFG_TPSU, 16'($urandom_range(3)));
    for (int i = 0; i < DEPTH + 2; i++)
      send_request(1'b0, now_ticks + 40'($urandom_range(50)), 16'($urandom),
                   16'($urandom_range(4)));
    empty_table();
    send_request(1'b1, '0, '0, '0);
    drain();
  endtask

  // Random mix of inserts and dispatches
  task automatic test_random(int n, logic [1:0] m, logic [15:0] tpsu);
    logic [39:0] arr;
    write_reg(drs_pkg::CFG_MODE, m);
    write_reg(drs_pkg::CFG_TPSU, tpsu);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0: arr = 40'({$urandom, $urandom});
        1: arr = MASK40 - 40'($urandom_range(3));
        default: arr = now_ticks + 40'($urandom_range(2000));
      endcase
      if ($urandom_range(99) < 55)
        send_request(1'b0, arr, ($urandom_range(3) == 0) ? 16'($urandom) :
                     16'($urandom_range(200)), ($urandom_range(7) == 0) ?
                     16'($urandom) : 16'($urandom_range(20)));
      else
        send_request(1'b1, 40'({$urandom, $urandom}), 16'($urandom), 16'($urandom));
    end
    empty_table();
    drain();
  endtask

  // Long receiver hold-off while the sender keeps offering items
  task automatic test_backpressure();
    int held;
    set_idling(0, 0);
    fork
      begin
        hold_off = 1;
        held = 0;
        while (held < 2000) begin
          @(posedge clk_i);
          held++;
        end
        hold_off = 0;
      end
      for (int i = 0; i < 6; i++)
        send_request(1'b0, now_ticks, 16'($urandom), 16'($urandom_range(5)));
    join
    empty_table();
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    func_i = 1'b0;
    arrival_time_i = '0;
    target_cylinder_i = '0;
    request_size_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 0;
    order_cnt = 0;
    now_ticks = 0;
    head_cyl = 0;
    going_up = 1;
    cur_mode = drs_pkg::MODE_FCFS;
    cur_tpsu = 16'd1;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(0, 0);
    test_directed();
    test_table_full(drs_pkg::MODE_SCAN);
    test_random(80, drs_pkg::MODE_FCFS, 16'd1);
    set_idling(49, 0);
    test_random(80, drs_pkg::MODE_SSTF, 16'd7);
    set_idling(0, 49);
    test_random(80, drs_pkg::MODE_SCAN, 16'd0);
    set_idling(35, 35);
    test_random(80, drs_pkg::MODE_CLOOK, 16'hFFFF);
    test_table_full(drs_pkg::MODE_CLOOK);
    test_backpressure();

    $display("Covered %0d results: %0d served, %0d table full, %0d nothing pending,",
             results_seen, served_cnt, full_cnt, none_cnt);
    $display("all four modes, tick scale extremes, idling phases and a long hold-off.");
    if (errors == 0)
      $display("disk_request_scheduler_tb: PASS");
    else
      $display("disk_request_scheduler_tb: FAIL");
    $finish;
  end

endmodule
